### hdl/tccs_pkg.sv
`timescale 1ns / 1ps

package tccs_pkg;

   localparam logic [1:0] CMD_PUT   = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [7:0] NEWLINE_CHAR    = 8'd10;
   localparam logic [7:0] SPACE_CHAR      = 8'h20;
   localparam logic [7:0] FILL_ATTR_RESET = 8'd15;

   localparam int ADDR_W      = 12;
   localparam int ROW_W       = 5;
   localparam int COL_W       = 7;
   localparam int INDEX_W     = 11;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [2:0] {
      OP_PUT,
      OP_NEWLINE,
      OP_CLEAR,
      OP_READ,
      OP_READ_NONE,
      OP_NOP
   } op_kind_type;

   typedef struct packed {
      op_kind_type       kind;
      logic [7:0]        char_code;
      logic [7:0]        char_attr;
      logic [ADDR_W-1:0] addr;
   } op_entry_type;

   typedef struct packed {
      logic              scrolled;
      logic [7:0]        cell_attr;
      logic [7:0]        cell_char;
      logic [INDEX_W-1:0] cursor_index;
      logic [COL_W-1:0]  out_col;
      logic [ROW_W-1:0]  out_row;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_COPY,
      ST_FILL
   } back_state_type;

   function automatic logic [ADDR_W-1:0] lin_index(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col,
                                                   input int cols);
      lin_index = ADDR_W'(row) * ADDR_W'(cols) + ADDR_W'(col);
   endfunction

endpackage

### hdl/tccs_ram.sv
`timescale 1ns / 1ps

module tccs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/tccs_front.sv
`timescale 1ns / 1ps

module tccs_front import tccs_pkg::*; #(
   parameter int COLS = 80,
   parameter int ROWS = 25
) (
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [1:0]       cmd,
   input  logic [7:0]       char_code,
   input  logic [7:0]       char_attr,
   input  logic [ROW_W-1:0] query_row,
   input  logic [COL_W-1:0] query_col,
   input  logic             init_done,
   input  logic             q_full,
   output logic             q_push,
   output op_entry_type     q_entry
);

   logic in_range;

   assign req_tready = init_done && !q_full;
   assign q_push     = req_tvalid && req_tready;
   assign in_range   = ({1'b0, query_row} < 6'(ROWS)) && ({1'b0, query_col} < 8'(COLS));

   always_comb begin
      q_entry.char_code = char_code;
      q_entry.char_attr = char_attr;
      q_entry.addr      = lin_index(query_row, query_col, COLS);
      unique case (cmd)
         CMD_PUT:   q_entry.kind = (char_code == NEWLINE_CHAR) ? OP_NEWLINE : OP_PUT;
         CMD_CLEAR: q_entry.kind = OP_CLEAR;
         CMD_READ:  q_entry.kind = in_range ? OP_READ : OP_READ_NONE;
         default:   q_entry.kind = OP_NOP;
      endcase
   end

endmodule

### hdl/tccs_queue.sv
`timescale 1ns / 1ps

module tccs_queue import tccs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  op_entry_type push_entry,
   output logic         full,
   input  logic         pop,
   output logic         head_valid,
   output op_entry_type head_entry
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   op_entry_type    mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PW:0]     count_ff, count_in;

   assign full       = (count_ff == (PW+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### hdl/tccs_back.sv
`timescale 1ns / 1ps

module tccs_back import tccs_pkg::*; #(
   parameter int COLS = 80,
   parameter int ROWS = 25
) (
   input  logic         clock,
   input  logic         reset,
   input  logic [7:0]   fill_attr,
   input  logic         q_valid,
   input  op_entry_type q_entry,
   output logic         q_pop,
   output logic         init_done,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   localparam int N  = ROWS * COLS;
   localparam int AW = $clog2(N);
   localparam int CW = $clog2(N + 1);

   back_state_type   state_ff, state_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             pend_ff, pend_in;
   logic [AW-1:0]    wa_ff, wa_in;
   logic [ROW_W-1:0] line_ff, line_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic             scr_ff, scr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_ff, rsp_in;

   logic             wr_en;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic [15:0]      wr_data, rd_data;

   logic             slot_free;
   logic [ROW_W:0]   line_inc;
   logic [COL_W:0]   col_inc;
   logic             wrap, scroll;
   logic [ADDR_W-1:0] cur_addr;
   logic [ADDR_W-1:0] idx_cur;

   tccs_ram #(.WIDTH(16), .DEPTH(N)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign line_inc  = {1'b0, line_ff} + 1'b1;
   assign col_inc   = {1'b0, col_ff} + 1'b1;
   assign wrap      = (q_entry.kind == OP_NEWLINE) || (col_inc == (COL_W+1)'(COLS));
   assign scroll    = wrap && (line_inc == (ROW_W+1)'(ROWS));
   assign cur_addr  = lin_index(line_ff, col_ff, COLS);
   assign idx_cur   = cur_addr;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pend_in      = 1'b0;
      wa_in        = wa_ff;
      line_in      = line_ff;
      col_in       = col_ff;
      scr_in       = scr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_addr      = '0;
      q_pop        = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff[AW-1:0];
            wr_data = {FILL_ATTR_RESET, SPACE_CHAR};
            if (cnt_ff == CW'(N - 1)) begin
               state_in = ST_IDLE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (q_valid && slot_free) begin
               q_pop = 1'b1;
               unique case (q_entry.kind)
                  OP_PUT, OP_NEWLINE: begin
                     if (q_entry.kind == OP_PUT) begin
                        wr_en   = 1'b1;
                        wr_addr = cur_addr[AW-1:0];
                        wr_data = {q_entry.char_attr, q_entry.char_code};
                     end
                     if (scroll) begin
                        line_in  = ROW_W'(ROWS - 1);
                        col_in   = '0;
                        scr_in   = 1'b1;
                        cnt_in   = CW'(COLS);
                        state_in = ST_COPY;
                     end else begin
                        line_in      = wrap ? line_inc[ROW_W-1:0] : line_ff;
                        col_in       = wrap ? '0 : col_inc[COL_W-1:0];
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{1'b0, 8'd0, 8'd0,
                                         INDEX_W'(lin_index(line_in, col_in, COLS)),
                                         col_in, line_in};
                     end
                  end
                  OP_CLEAR: begin
                     line_in  = '0;
                     col_in   = '0;
                     scr_in   = 1'b0;
                     cnt_in   = '0;
                     state_in = ST_FILL;
                  end
                  OP_READ: begin
                     rd_addr  = q_entry.addr[AW-1:0];
                     state_in = ST_READ;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{1'b0, 8'd0, 8'd0, idx_cur[INDEX_W-1:0],
                                      col_ff, line_ff};
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '{1'b0, rd_data[15:8], rd_data[7:0], idx_cur[INDEX_W-1:0],
                             col_ff, line_ff};
            state_in     = ST_IDLE;
         end
         ST_COPY: begin
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = wa_ff;
               wr_data = rd_data;
            end
            if (cnt_ff < CW'(N)) begin
               rd_addr = cnt_ff[AW-1:0];
               pend_in = 1'b1;
               wa_in   = AW'(cnt_ff - CW'(COLS));
               cnt_in  = cnt_ff + 1'b1;
            end else begin
               cnt_in   = CW'(N - COLS);
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff[AW-1:0];
            wr_data = {fill_attr, SPACE_CHAR};
            if (cnt_ff == CW'(N - 1)) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{scr_ff, 8'd0, 8'd0, idx_cur[INDEX_W-1:0], col_ff, line_ff};
               state_in     = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         line_ff      <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         line_ff      <= line_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wa_ff  <= wa_in;
      scr_ff <= scr_in;
      rsp_ff <= rsp_in;
   end

   assign init_done = (state_ff != ST_INIT);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

### hdl/text_console_cursor_scroll_unit.sv
`timescale 1ns / 1ps
// responses: put, newline and unused commands pass the queue, then the back end registers the
// response; a read waits in ST_READ for registered store data. throughput: one put or newline
// per cycle while rsp_tready is high and no scroll occurs; the next request waits for a read to
// finish. clear and scroll make one store write per cycle. reset: cursor homes, fill
// attribute returns to 15, then a clearing pass stores spaces while req_tready stays low

module text_console_cursor_scroll_unit import tccs_pkg::*; #(
   parameter int COLS = 80,
   parameter int ROWS = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   // char_code, char_attr, query_row, query_col, zero pad
   input  logic [31:0] req_tdata,
   // cmd
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_row, out_col, cursor_index, cell_char, cell_attr, scrolled
   output logic [39:0] rsp_tdata
);

   logic [7:0]   fill_attr_ff, fill_attr_in;
   logic         init_done;
   logic         q_full, q_push, q_pop, q_valid;
   op_entry_type push_entry, head_entry;
   rsp_item_type rsp_item;

   assign fill_attr_in = csr_wr_en ? csr_wr_data : fill_attr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_attr_ff <= FILL_ATTR_RESET;
      end else begin
         fill_attr_ff <= fill_attr_in;
      end
   end

   tccs_front #(.COLS(COLS), .ROWS(ROWS)) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (req_tuser),
      .char_code  (req_tdata[7:0]),
      .char_attr  (req_tdata[15:8]),
      .query_row  (req_tdata[20:16]),
      .query_col  (req_tdata[27:21]),
      .init_done  (init_done),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (push_entry)
   );

   tccs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_entry (head_entry)
   );

   tccs_back #(.COLS(COLS), .ROWS(ROWS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .fill_attr (fill_attr_ff),
      .q_valid   (q_valid),
      .q_entry   (head_entry),
      .q_pop     (q_pop),
      .init_done (init_done),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_item  (rsp_item)
   );

   assign rsp_tdata = rsp_item;

endmodule

### hdl/tccs_checker.sv
`timescale 1ns / 1ps

module tccs_checker import tccs_pkg::*; #(
   parameter int COLS = 80,
   parameter int ROWS = 25
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   logic [ADDR_W-1:0] exp_index;

   assign exp_index = lin_index(rsp_tdata[4:0], rsp_tdata[11:5], COLS);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ({1'b0, rsp_tdata[4:0]} < 6'(ROWS)) && ({1'b0, rsp_tdata[11:5]} < 8'(COLS)))
      else $error("cursor out of range");

   a_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[22:12] == exp_index[INDEX_W-1:0])
      else $error("cursor index mismatch");

   a_scroll_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[39] |->
         rsp_tdata[4:0] == 5'(ROWS - 1) && rsp_tdata[11:5] == '0)
      else $error("scroll left cursor off the bottom row start");

   a_init_stall: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request taken during clearing pass");

endmodule

bind text_console_cursor_scroll_unit tccs_checker #(.COLS(COLS), .ROWS(ROWS)) u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
